// ===== rtl/core/ttc_pkg.sv =====
package ttc_pkg;

	localparam int DIFF_W = 17;
	localparam int PROD_W = 34;
	localparam int ACC_W  = 35;
	localparam int MAG_W  = 34;
	localparam int LIM_W  = 30;
	localparam int SQ_W   = 60;
	localparam int SUM_W  = 62;
	localparam int ROOT_W = 63;
	localparam int LEN_W  = 32;
	localparam int REM_W  = 33;
	localparam int OUT_W  = 16;
	localparam int SAT_POS = 32767;
	localparam int SAT_NEG = 32768;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] tex_u;
		logic signed [15:0] tex_v;
	} vtx_t;

	typedef struct packed {
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] tangent_z;
		logic               degenerate;
	} tan_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ABS,
		ST_NORM,
		ST_SQR,
		ST_ROOT,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/triangle_tangent_calculator_unit.sv =====
// channel | beat                 | handshake
// in      | one vertex (vtx_t)   | in_valid / in_ready
// out     | one tangent (tan_t)  | out_valid / out_ready
//
// First and second vertex of a triangle: stored, with no further work.
// Third vertex: edge and texture deltas registered, then the shared 17x17 multiplier, the
//   magnitude step, the range shift, the squares, the bit-serial root and a bit-serial divide
//   per tangent component; a degenerate triangle skips the remaining steps.
// Reset clears the vertex count, the sequencer and the output valid.
// A waiting result does not block vertices; a new triangle waits in ST_DONE only if the
//   previous result has not been taken.
module triangle_tangent_calculator_unit #(
	parameter int COORD_BITS        = 16,
	parameter int TANGENT_FRAC_BITS = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ttc_pkg::vtx_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ttc_pkg::tan_t   out_data
);

	localparam int CB        = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int PRE_SHIFT = (COORD_BITS > 16) ? COORD_BITS - 16 : 0;
	localparam int FW        = TANGENT_FRAC_BITS;
	localparam int QW        = FW + 1;
	localparam int NW        = ttc_pkg::LIM_W + FW + 1;
	localparam int CNT_W     = $clog2(QW + 1);

	function automatic logic signed [ttc_pkg::DIFF_W-1:0] ext(input logic [15:0] f);
		logic signed [ttc_pkg::DIFF_W-1:0] r;
		if (COORD_BITS > 16) begin
			r = {1'b0, f};
		end else begin
			r = {{(ttc_pkg::DIFF_W-CB){f[CB-1]}}, f[CB-1:0]};
		end
		return r;
	endfunction

	function automatic logic signed [ttc_pkg::DIFF_W-1:0] dif(
		input logic signed [ttc_pkg::DIFF_W-1:0] a,
		input logic signed [ttc_pkg::DIFF_W-1:0] b
	);
		logic signed [ttc_pkg::DIFF_W:0] d;
		d = {a[ttc_pkg::DIFF_W-1], a} - {b[ttc_pkg::DIFF_W-1], b};
		d = d >>> PRE_SHIFT;
		return d[ttc_pkg::DIFF_W-1:0];
	endfunction

	ttc_pkg::state_t state_q, state_d;
	ttc_pkg::vtx_t   v0_q, v1_q;
	logic [1:0]      slot_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]      comp_q;

	logic signed [ttc_pkg::DIFF_W-1:0] e1_q [3];
	logic signed [ttc_pkg::DIFF_W-1:0] e2_q [3];
	logic signed [ttc_pkg::DIFF_W-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [ttc_pkg::DIFF_W-1:0] mul_a, mul_b;
	logic signed [ttc_pkg::PROD_W-1:0] prod_d, prod_q;
	logic signed [ttc_pkg::ACC_W-1:0]  det_q;
	logic signed [ttc_pkg::ACC_W-1:0]  t_q [3];
	logic [ttc_pkg::MAG_W-1:0]         mag_q [3];
	logic [ttc_pkg::MAG_W-1:0]         mag_d [3];
	logic                              sgn_q [3];
	logic                              sgn_d [3];
	logic [ttc_pkg::SQ_W-1:0]          sq_q;
	logic [ttc_pkg::SUM_W-1:0]         sum_q;
	logic [ttc_pkg::ROOT_W-1:0]        n_q, res_q, bit_q, rb, res_d;
	logic                              root_ge;
	logic [ttc_pkg::LEN_W-1:0]         len_q;
	logic [ttc_pkg::REM_W-1:0]         drem_q, r2;
	logic [QW-1:0]                     nlo_q, quo_q, quo_d;
	logic [NW-1:0]                     num;
	logic                              div_ge;
	logic [ttc_pkg::LIM_W-1:0]         dmag;
	logic [ttc_pkg::OUT_W:0]           qs, qn;
	logic signed [ttc_pkg::OUT_W-1:0]  comp_val;
	logic signed [ttc_pkg::OUT_W-1:0]  tan_q [3];
	logic                              deg_q;
	logic                              out_valid_q;
	ttc_pkg::tan_t                     out_q;

	logic in_acc, load_out, abs_degen, norm_big, root_last, div_last;
	logic signed [ttc_pkg::DIFF_W-1:0] nv [5];

	assign in_acc = in_valid && in_ready;
	assign nv[0] = ext(in_data.pos_x);
	assign nv[1] = ext(in_data.pos_y);
	assign nv[2] = ext(in_data.pos_z);
	assign nv[3] = ext(in_data.tex_u);
	assign nv[4] = ext(in_data.tex_v);

	always_comb begin
		case (cnt_q)
			CNT_W'(0): begin mul_a = du1_q;   mul_b = dv2_q; end
			CNT_W'(1): begin mul_a = dv1_q;   mul_b = du2_q; end
			CNT_W'(2): begin mul_a = e1_q[0]; mul_b = dv2_q; end
			CNT_W'(3): begin mul_a = e2_q[0]; mul_b = dv1_q; end
			CNT_W'(4): begin mul_a = e1_q[1]; mul_b = dv2_q; end
			CNT_W'(5): begin mul_a = e2_q[1]; mul_b = dv1_q; end
			CNT_W'(6): begin mul_a = e1_q[2]; mul_b = dv2_q; end
			CNT_W'(7): begin mul_a = e2_q[2]; mul_b = dv1_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		prod_d = mul_a * mul_b;
	end

	always_comb begin
		logic [ttc_pkg::ACC_W-1:0] tn;
		for (int i = 0; i < 3; i++) begin
			tn = -t_q[i];
			sgn_d[i] = t_q[i][ttc_pkg::ACC_W-1] ^ det_q[ttc_pkg::ACC_W-1];
			mag_d[i] = t_q[i][ttc_pkg::ACC_W-1] ? tn[ttc_pkg::MAG_W-1:0]
				: t_q[i][ttc_pkg::MAG_W-1:0];
		end
		abs_degen = (det_q == '0) || ((t_q[0] == '0) && (t_q[1] == '0) && (t_q[2] == '0));
		norm_big = (|mag_q[0][ttc_pkg::MAG_W-1:ttc_pkg::LIM_W])
			|| (|mag_q[1][ttc_pkg::MAG_W-1:ttc_pkg::LIM_W])
			|| (|mag_q[2][ttc_pkg::MAG_W-1:ttc_pkg::LIM_W]);
	end

	always_comb begin
		rb = res_q + bit_q;
		root_ge = n_q >= rb;
		res_d = root_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
		root_last = bit_q == ttc_pkg::ROOT_W'(1);
	end

	always_comb begin
		dmag = mag_q[comp_q][ttc_pkg::LIM_W-1:0];
		num = NW'({dmag, {FW{1'b0}}}) + NW'(len_q >> 1);
		r2 = {drem_q[ttc_pkg::REM_W-2:0], nlo_q[QW-1]};
		div_ge = r2 >= ttc_pkg::REM_W'(len_q);
		quo_d = {quo_q[QW-2:0], div_ge};
		div_last = cnt_q == CNT_W'(QW);
		if (sgn_q[comp_q]) begin
			qs = (32'(quo_d) > 32'(ttc_pkg::SAT_NEG)) ? (ttc_pkg::OUT_W+1)'(ttc_pkg::SAT_NEG)
				: (ttc_pkg::OUT_W+1)'(quo_d);
			qn = -qs;
		end else begin
			qs = (32'(quo_d) > 32'(ttc_pkg::SAT_POS)) ? (ttc_pkg::OUT_W+1)'(ttc_pkg::SAT_POS)
				: (ttc_pkg::OUT_W+1)'(quo_d);
			qn = qs;
		end
		comp_val = qn[ttc_pkg::OUT_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ttc_pkg::ST_IDLE: begin
				if (in_acc && (slot_q inside {2'd2, 2'd3})) state_d = ttc_pkg::ST_MUL;
			end
			ttc_pkg::ST_MUL: begin
				if (cnt_q == CNT_W'(8)) state_d = ttc_pkg::ST_ABS;
			end
			ttc_pkg::ST_ABS: begin
				state_d = abs_degen ? ttc_pkg::ST_DONE : ttc_pkg::ST_NORM;
			end
			ttc_pkg::ST_NORM: begin
				if (!norm_big) state_d = ttc_pkg::ST_SQR;
			end
			ttc_pkg::ST_SQR: begin
				if (cnt_q == CNT_W'(3)) state_d = ttc_pkg::ST_ROOT;
			end
			ttc_pkg::ST_ROOT: begin
				if (root_last) state_d = (res_d == '0) ? ttc_pkg::ST_DONE : ttc_pkg::ST_DIV;
			end
			ttc_pkg::ST_DIV: begin
				if (div_last && comp_q == 2'd2) state_d = ttc_pkg::ST_DONE;
			end
			ttc_pkg::ST_DONE: begin
				if (load_out) state_d = ttc_pkg::ST_IDLE;
			end
			default: state_d = ttc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = state_q == ttc_pkg::ST_IDLE;
		load_out = (state_q == ttc_pkg::ST_DONE) && (!out_valid_q || out_ready);
		out_valid = out_valid_q;
		out_data = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttc_pkg::ST_IDLE;
			slot_q <= '0;
			cnt_q <= '0;
			comp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				slot_q <= (slot_q inside {2'd2, 2'd3}) ? 2'd0 : slot_q + 2'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ttc_pkg::ST_MUL, ttc_pkg::ST_SQR: begin
					cnt_q <= (state_d == state_q) ? cnt_q + CNT_W'(1) : '0;
				end
				ttc_pkg::ST_ROOT: begin
					cnt_q <= '0;
					comp_q <= '0;
				end
				ttc_pkg::ST_DIV: begin
					if (div_last) begin
						cnt_q <= '0;
						comp_q <= comp_q + 2'd1;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ttc_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (slot_q == 2'd0) v0_q <= in_data;
					if (slot_q == 2'd1) v1_q <= in_data;
					e1_q[0] <= dif(ext(v1_q.pos_x), ext(v0_q.pos_x));
					e1_q[1] <= dif(ext(v1_q.pos_y), ext(v0_q.pos_y));
					e1_q[2] <= dif(ext(v1_q.pos_z), ext(v0_q.pos_z));
					e2_q[0] <= dif(nv[0], ext(v0_q.pos_x));
					e2_q[1] <= dif(nv[1], ext(v0_q.pos_y));
					e2_q[2] <= dif(nv[2], ext(v0_q.pos_z));
					du1_q <= dif(ext(v1_q.tex_u), ext(v0_q.tex_u));
					dv1_q <= dif(ext(v1_q.tex_v), ext(v0_q.tex_v));
					du2_q <= dif(nv[3], ext(v0_q.tex_u));
					dv2_q <= dif(nv[4], ext(v0_q.tex_v));
				end
			end
			ttc_pkg::ST_MUL: begin
				prod_q <= prod_d;
				case (cnt_q)
					CNT_W'(1): det_q <= ttc_pkg::ACC_W'(prod_q);
					CNT_W'(2): det_q <= det_q - ttc_pkg::ACC_W'(prod_q);
					CNT_W'(3): t_q[0] <= ttc_pkg::ACC_W'(prod_q);
					CNT_W'(4): t_q[0] <= t_q[0] - ttc_pkg::ACC_W'(prod_q);
					CNT_W'(5): t_q[1] <= ttc_pkg::ACC_W'(prod_q);
					CNT_W'(6): t_q[1] <= t_q[1] - ttc_pkg::ACC_W'(prod_q);
					CNT_W'(7): t_q[2] <= ttc_pkg::ACC_W'(prod_q);
					CNT_W'(8): t_q[2] <= t_q[2] - ttc_pkg::ACC_W'(prod_q);
					default: ;
				endcase
			end
			ttc_pkg::ST_ABS: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= mag_d[i];
					sgn_q[i] <= sgn_d[i];
					tan_q[i] <= '0;
				end
				deg_q <= abs_degen;
			end
			ttc_pkg::ST_NORM: begin
				if (norm_big) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end
			end
			ttc_pkg::ST_SQR: begin
				if (cnt_q != CNT_W'(3)) begin
					sq_q <= mag_q[cnt_q[1:0]][ttc_pkg::LIM_W-1:0]
						* mag_q[cnt_q[1:0]][ttc_pkg::LIM_W-1:0];
				end
				if (cnt_q == CNT_W'(1)) begin
					sum_q <= ttc_pkg::SUM_W'(sq_q);
				end else if (cnt_q != CNT_W'(0)) begin
					sum_q <= sum_q + ttc_pkg::SUM_W'(sq_q);
				end
				if (cnt_q == CNT_W'(3)) begin
					n_q <= ttc_pkg::ROOT_W'(sum_q + ttc_pkg::SUM_W'(sq_q));
					res_q <= '0;
					bit_q <= ttc_pkg::ROOT_W'(1) << (ttc_pkg::ROOT_W - 1);
				end
			end
			ttc_pkg::ST_ROOT: begin
				if (root_ge) n_q <= n_q - rb;
				res_q <= res_d;
				bit_q <= bit_q >> 2;
				if (root_last) begin
					len_q <= res_d[ttc_pkg::LEN_W-1:0];
					if (res_d == '0) deg_q <= 1'b1;
				end
			end
			ttc_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					drem_q <= ttc_pkg::REM_W'(num[NW-1:QW]);
					nlo_q <= num[QW-1:0];
					quo_q <= '0;
				end else begin
					drem_q <= div_ge ? r2 - ttc_pkg::REM_W'(len_q) : r2;
					nlo_q <= nlo_q << 1;
					quo_q <= quo_d;
					if (div_last) tan_q[comp_q] <= comp_val;
				end
			end
			ttc_pkg::ST_DONE: begin
				if (load_out) begin
					out_q.tangent_x <= tan_q[0];
					out_q.tangent_y <= tan_q[1];
					out_q.tangent_z <= tan_q[2];
					out_q.degenerate <= deg_q;
				end
			end
			default: ;
		endcase
	end

endmodule
